[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file shash_checker.sv.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[hw/rtl/shash_pkg.sv]
// Shared types, constants and helper functions of the SHA-256 stream hasher.
// No dependencies.
`timescale 1ns / 1ps

package shash_pkg;

  typedef logic [31:0] shash_word_t;
  typedef shash_word_t [0:7] shash_state_t;

  typedef struct packed {
    logic start;
    logic init;
  } shash_ctrl_t;

  localparam int unsigned ROUNDS = 64;
  localparam int unsigned BLOCK_BITS = 512;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  localparam shash_state_t INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam shash_word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic shash_word_t big_sigma0(input shash_word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic shash_word_t big_sigma1(input shash_word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic shash_word_t small_sigma0(input shash_word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic shash_word_t small_sigma1(input shash_word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

[hw/rtl/shash_round.sv]
// One SHA-256 compression round on the eight working variables.
// Depends on shash_pkg.
`timescale 1ns / 1ps

module shash_round
  import shash_pkg::*;
(
  input  shash_state_t v_in,
  input  shash_word_t  k_in,
  input  shash_word_t  w_in,
  output shash_state_t v_out
);

  shash_word_t ch;
  shash_word_t maj;
  shash_word_t t1;
  shash_word_t t2;

  assign ch  = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
  assign maj = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
  assign t1  = v_in[7] + big_sigma1(v_in[4]) + ch + k_in + w_in;
  assign t2  = big_sigma0(v_in[0]) + maj;

  assign v_out[0] = t1 + t2;
  assign v_out[1] = v_in[0];
  assign v_out[2] = v_in[1];
  assign v_out[3] = v_in[2];
  assign v_out[4] = v_in[3] + t1;
  assign v_out[5] = v_in[4];
  assign v_out[6] = v_in[5];
  assign v_out[7] = v_in[6];

endmodule

[hw/rtl/shash_core.sv]
// Iterative compression engine: chaining words, message schedule window,
// round counter; one round per cycle through shash_round. Depends on shash_pkg.
`timescale 1ns / 1ps

module shash_core
  import shash_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  shash_ctrl_t           ctrl,
  input  logic [BLOCK_BITS-1:0] block,
  output logic                  done,
  output shash_state_t          digest
);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_ADD   = 3'b100
  } core_state_t;

  core_state_t  cst_r, cst_nxt;
  shash_state_t h_r, h_nxt;
  shash_state_t v_r, v_nxt;
  shash_state_t v_round;
  shash_word_t  w_r [16];
  shash_word_t  w_nxt [16];
  shash_word_t  w_new;
  logic [5:0]   rnd_r, rnd_nxt;

  shash_round u_round (
    .v_in  (v_r),
    .k_in  (ROUND_K[rnd_r]),
    .w_in  (w_r[0]),
    .v_out (v_round)
  );

  assign w_new  = small_sigma1(w_r[14]) + w_r[9] + small_sigma0(w_r[1]) + w_r[0];
  assign done   = (cst_r == C_ADD);
  assign digest = h_r;

  always_comb begin
    cst_nxt = cst_r;
    h_nxt   = h_r;
    v_nxt   = v_r;
    rnd_nxt = rnd_r;
    for (int i = 0; i < 16; i++) begin
      w_nxt[i] = w_r[i];
    end
    case (cst_r)
      C_IDLE: begin
        if (ctrl.init) begin
          h_nxt = INIT_HASH;
        end
        if (ctrl.start) begin
          v_nxt   = h_r;
          rnd_nxt = 6'd0;
          for (int i = 0; i < 16; i++) begin
            w_nxt[i] = block[BLOCK_BITS-1-32*i -: 32];
          end
          cst_nxt = C_ROUND;
        end
      end
      C_ROUND: begin
        v_nxt   = v_round;
        rnd_nxt = rnd_r + 6'd1;
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = w_new;
        if (rnd_r == 6'd63) begin
          cst_nxt = C_ADD;
        end
      end
      C_ADD: begin
        for (int i = 0; i < 8; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        cst_nxt = C_IDLE;
      end
      default: begin
        cst_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cst_r <= C_IDLE;
      h_r   <= INIT_HASH;
      rnd_r <= 6'd0;
    end else begin
      cst_r <= cst_nxt;
      h_r   <= h_nxt;
      rnd_r <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    for (int i = 0; i < 16; i++) begin
      w_r[i] <= w_nxt[i];
    end
  end

endmodule

[hw/rtl/sha256_stream_hasher.sv]
// SHA-256 stream hasher top level: byte buffer, padding sequencer, digest output.
// Depends on shash_pkg, shash_core (and shash_round below it).
//
// Usage:
//   Input channel (in_valid / in_stall): one request per message byte, with
//   in_byte_present marking a real byte and in_end_of_message closing the message.
//   A request with only the end mark hashes an empty message.
//   Output channel (out_valid / out_stall): four requests per closed message,
//   64 digest bits each, part 0 most significant, out_last_part on part 3.
// Timing:
//   A byte that neither fills the block nor closes the message leaves in_stall
//   low. The 64th byte of a block starts the compression, with in_stall high
//   (one round per cycle in the shared round unit plus load and final add).
//   After the end mark, padding shifts one byte per cycle up to the block end,
//   then each padded block is compressed (two blocks if more than 55 bytes were held),
//   then the four digest parts on consecutive cycles unless stalled.
// Reset: synchronous, active low; the chaining words return to the initial hash
//   and the block is empty. A stalled digest part holds until taken; no new
//   input is taken before the fourth part leaves.
`timescale 1ns / 1ps

module sha256_stream_hasher
  import shash_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_part,
  output logic [1:0]  out_part_index,
  output logic        out_last_part
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAD  = 4'b0010,
    S_COMP = 4'b0100,
    S_OUT  = 4'b1000
  } top_state_t;

  top_state_t            state_r, state_nxt;
  logic [BLOCK_BITS-1:0] block_r;
  logic [5:0]            fill_r, fill_nxt;
  logic [63:0]           bits_r, bits_nxt;
  logic                  mark_r, mark_nxt;
  logic                  len_ok_r, len_ok_nxt;
  logic                  pad_ctx_r, pad_ctx_nxt;
  logic                  eom_pend_r, eom_pend_nxt;
  logic [1:0]            part_r, part_nxt;
  logic                  start_r, start_nxt;
  logic                  shift_en;
  logic [7:0]            shift_byte;
  logic [63:0]           len_shift;
  logic                  core_done;
  shash_state_t          digest;
  shash_ctrl_t           ctrl;

  assign ctrl.start = start_r;
  assign ctrl.init  = (state_r == S_OUT) && !out_stall && (part_r == 2'd3);

  shash_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .block  (block_r),
    .done   (core_done),
    .digest (digest)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_part_index  = part_r;
  assign out_last_part   = (part_r == 2'd3);
  assign out_digest_part = {digest[{part_r, 1'b0}], digest[{part_r, 1'b1}]};
  assign len_shift       = bits_r >> {~fill_r[2:0], 3'b000};

  always_comb begin
    state_nxt    = state_r;
    bits_nxt     = bits_r;
    mark_nxt     = mark_r;
    len_ok_nxt   = len_ok_r;
    pad_ctx_nxt  = pad_ctx_r;
    eom_pend_nxt = eom_pend_r;
    part_nxt     = part_r;
    start_nxt    = 1'b0;
    shift_en     = 1'b0;
    shift_byte   = 8'h00;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          eom_pend_nxt = in_end_of_message;
          if (in_byte_present) begin
            shift_en   = 1'b1;
            shift_byte = in_data_byte;
            bits_nxt   = bits_r + 64'd8;
          end
          if (in_byte_present && (fill_r == 6'd63)) begin
            state_nxt = S_COMP;
            start_nxt = 1'b1;
          end else if (in_end_of_message) begin
            state_nxt   = S_PAD;
            mark_nxt    = 1'b1;
            len_ok_nxt  = 1'b0;
            pad_ctx_nxt = 1'b1;
          end
        end
      end
      S_PAD: begin
        shift_en = 1'b1;
        if (mark_r) begin
          shift_byte = PAD_MARK;
          mark_nxt   = 1'b0;
          len_ok_nxt = (fill_r < LEN_START);
        end else if (len_ok_r && (fill_r >= LEN_START)) begin
          shift_byte = len_shift[7:0];
        end
        if (fill_r == 6'd63) begin
          state_nxt = S_COMP;
          start_nxt = 1'b1;
        end
      end
      S_COMP: begin
        if (core_done) begin
          if (pad_ctx_r) begin
            if (len_ok_r) begin
              state_nxt = S_OUT;
              part_nxt  = 2'd0;
            end else begin
              state_nxt  = S_PAD;
              len_ok_nxt = 1'b1;
            end
          end else if (eom_pend_r) begin
            state_nxt   = S_PAD;
            mark_nxt    = 1'b1;
            len_ok_nxt  = 1'b0;
            pad_ctx_nxt = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          part_nxt = part_r + 2'd1;
          if (part_r == 2'd3) begin
            state_nxt    = S_IDLE;
            bits_nxt     = 64'd0;
            pad_ctx_nxt  = 1'b0;
            eom_pend_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    fill_nxt = shift_en ? (fill_r + 6'd1) : fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= 6'd0;
      bits_r     <= 64'd0;
      mark_r     <= 1'b0;
      len_ok_r   <= 1'b0;
      pad_ctx_r  <= 1'b0;
      eom_pend_r <= 1'b0;
      part_r     <= 2'd0;
      start_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      bits_r     <= bits_nxt;
      mark_r     <= mark_nxt;
      len_ok_r   <= len_ok_nxt;
      pad_ctx_r  <= pad_ctx_nxt;
      eom_pend_r <= eom_pend_nxt;
      part_r     <= part_nxt;
      start_r    <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      block_r <= {block_r[BLOCK_BITS-9:0], shift_byte};
    end
  end

endmodule

[hw/rtl/shash_checker.sv]
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module shash_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_digest_part,
  input logic [1:0]  out_part_index,
  input logic        out_last_part
);

  // no input request is taken while a digest is being delivered
  `ASSERT_IMP(a_out_blocks_in, out_valid, in_stall)

  `ASSERT_IMP(a_last_flag, out_valid, out_last_part == (out_part_index == 2'd3))

  // digest parts follow one another without a gap
  `ASSERT_NXT(a_parts_back_to_back, out_valid && !out_stall && !out_last_part, out_valid && (out_part_index == $past(out_part_index) + 2'd1))

  `ASSERT_NXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(out_digest_part) && $stable(out_part_index))

endmodule

bind sha256_stream_hasher shash_checker u_shash_checker (.*);
